@@ hw/rtl/mean_and_std_deviation_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MEAN_AND_STD_DEVIATION_UNIT_MACROS_SVH
`define MEAN_AND_STD_DEVIATION_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/msd_pkg.sv @@
// ----------------------------------------------------------------------------
// msd_pkg
// Widths, constants and shared types of the mean and deviation unit.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int RESULT_W    = 16;

  localparam int COUNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int LOG_MAX  = $clog2(MAX_SAMPLES);
  localparam int SQ_W     = 2 * SAMPLE_W - 1;
  localparam int SUM_W    = SAMPLE_W + LOG_MAX;
  localparam int SUMSQ_W  = SQ_W + LOG_MAX;

  // Widths of the closing arithmetic: N*sumsq, sum^2 and their difference.
  localparam int A_W      = SUMSQ_W + COUNT_W;
  localparam int P_W      = (A_W > 2 * SUM_W) ? A_W : 2 * SUM_W;
  localparam int ROOT_W   = (P_W + 1) / 2;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int DIV_W    = (ROOT_W > SUM_W) ? ROOT_W : SUM_W;
  localparam int MAX_ITER = (ROOT_W > COUNT_W) ? ROOT_W : COUNT_W;
  localparam int STEP_W   = $clog2(MAX_ITER);
  localparam int DSTEP_W  = $clog2(DIV_W);

  localparam int Q_DEPTH  = 4;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QLVL_W   = $clog2(Q_DEPTH + 1);

  // One closed set, as handed from the accumulator to the finisher.
  typedef struct packed {
    logic                      ovf;
    logic [COUNT_W-1:0]        n;
    logic signed [SUM_W-1:0]   sum;
    logic [SUMSQ_W-1:0]        sumsq;
  } msd_set_t;

  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } msd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } msd_div_rsp_t;

endpackage

@@ hw/rtl/msd_if.sv @@
// ----------------------------------------------------------------------------
// msd_if
// Valid/ready channels for samples in and set results out.
// ----------------------------------------------------------------------------
interface msd_in_if import msd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                has_sample;
  logic                last;

  modport source (output valid, sample, has_sample, last, input ready);
  modport sink   (input valid, sample, has_sample, last, output ready);
endinterface

interface msd_out_if import msd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] mean;
  logic [RESULT_W-1:0] std_dev;
  logic [COUNT_W-1:0]  sample_count;
  logic                overflowed;

  modport source (output valid, mean, std_dev, sample_count, overflowed, input ready);
  modport sink   (input valid, mean, std_dev, sample_count, overflowed, output ready);
endinterface

@@ hw/rtl/msd_front.sv @@
// ----------------------------------------------------------------------------
// msd_front
// Takes one sample a cycle while ready; keeps count, sum and sum of squares.
// ----------------------------------------------------------------------------
module msd_front import msd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  msd_in_if.sink          samples,
  input  logic [QLVL_W-1:0] level,
  output logic            push,
  output msd_set_t        push_set
);

  logic [COUNT_W-1:0]      count;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;
  logic [SUMSQ_W-1:0]      sumsq;

  // Second stage: the registered square and the snapshot of a closing set.
  logic [SQ_W-1:0]         sq;
  logic                    close;
  logic [COUNT_W-1:0]      close_n;
  logic signed [SUM_W-1:0] close_sum;
  logic                    close_ovf;

  logic                    accept;
  logic                    full;
  logic                    take;
  logic [SAMPLE_W-1:0]     mag;
  logic [2*SAMPLE_W-1:0]   sq_full;
  logic signed [SUM_W-1:0] x;
  logic [COUNT_W-1:0]      count_next;
  logic signed [SUM_W-1:0] sum_next;
  logic                    ovf_next;
  logic [SUMSQ_W-1:0]      sumsq_next;

  // A closing set still in the second stage will take a queue slot too.
  assign samples.ready = (level + QLVL_W'(close)) < QLVL_W'(Q_DEPTH);
  assign accept = samples.valid && samples.ready;

  always_comb begin
    full       = count >= COUNT_W'(MAX_SAMPLES);
    take       = samples.has_sample && !full;
    x          = {{(SUM_W - SAMPLE_W){samples.sample[SAMPLE_W-1]}}, samples.sample};
    mag        = samples.sample[SAMPLE_W-1] ? (~samples.sample + 1'b1) : samples.sample;
    sq_full    = mag * mag;
    count_next = take ? count + 1'b1 : count;
    sum_next   = take ? sum + x : sum;
    ovf_next   = ovf | (samples.has_sample && full);
    sumsq_next = sumsq + SUMSQ_W'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      ovf   <= 1'b0;
      sumsq <= '0;
      sq    <= '0;
      close <= 1'b0;
    end else begin
      close <= accept && samples.last;
      sq    <= (accept && take) ? sq_full[SQ_W-1:0] : '0;
      if (accept) begin
        if (samples.last) begin
          count <= '0;
          sum   <= '0;
          ovf   <= 1'b0;
        end else begin
          count <= count_next;
          sum   <= sum_next;
          ovf   <= ovf_next;
        end
      end
      sumsq <= close ? '0 : sumsq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && samples.last) begin
      close_n   <= count_next;
      close_sum <= sum_next;
      close_ovf <= ovf_next;
    end
  end

  assign push           = close;
  assign push_set.ovf   = close_ovf;
  assign push_set.n     = close_n;
  assign push_set.sum   = close_sum;
  assign push_set.sumsq = sumsq_next;

endmodule

@@ hw/rtl/msd_queue.sv @@
// ----------------------------------------------------------------------------
// msd_queue
// Short FIFO of closed sets between the accumulator and the finisher.
// ----------------------------------------------------------------------------
`include "mean_and_std_deviation_unit_macros.svh"

module msd_queue import msd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  msd_set_t          push_set,
  input  logic              pop,
  output msd_set_t          head,
  output logic              nonempty,
  output logic [QLVL_W-1:0] level
);

  msd_set_t          mem [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_set;
    end
  end

  assign head     = mem[rd_ptr];
  assign nonempty = level != '0;

  `MSD_ASSERT_SAME(q_no_overflow, push && !pop, level != QLVL_W'(Q_DEPTH), "queue written while full")
  `MSD_ASSERT_SAME(q_no_underflow, pop, level != '0, "queue read while empty")
  `MSD_ASSERT_NEXT(q_level_up, push && !pop, level == $past(level) + 1'b1, "queue level did not rise")

endmodule

@@ hw/rtl/msd_div.sv @@
// ----------------------------------------------------------------------------
// msd_div
// Restoring divider by the sample count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msd_div import msd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  msd_div_req_t req,
  output msd_div_rsp_t rsp
);

  logic               busy;
  logic               done;
  logic [DSTEP_W-1:0] step;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W-1:0] rem;
  logic [DIV_W-1:0]   quo;
  logic [COUNT_W:0]   trial;
  logic               fits;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == DSTEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      rem     <= '0;
      quo     <= req.dividend;
    end else if (busy) begin
      rem <= fits ? COUNT_W'(trial - {1'b0, divisor}) : trial[COUNT_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ hw/rtl/msd_back.sv @@
// ----------------------------------------------------------------------------
// msd_back
// Finishes one closed set: mean, variance numerator, square root, divides.
// ----------------------------------------------------------------------------
module msd_back import msd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  msd_set_t head,
  input  logic     nonempty,
  output logic     pop,
  msd_out_if.source results
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_SUB,
    S_ROOT,
    S_DIV_SD,
    S_WAIT_SD,
    S_DIV_MEAN,
    S_WAIT_MEAN,
    S_OUT
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] mplier;
  logic               neg;
  logic               ovf;
  logic [SUM_W-1:0]   smag;
  logic [P_W-1:0]     mcand;
  logic [P_W-1:0]     acc;
  logic [P_W-1:0]     sq_sum;
  logic [RAD_W-1:0]   rad;
  logic [ROOT_W-1:0]  root;
  logic [REM_W-1:0]   rem;
  logic [STEP_W-1:0]  step;
  logic [RESULT_W-1:0] mean;
  logic [RESULT_W-1:0] sd;
  logic               out_valid;

  logic [SUM_W-1:0]   head_mag;
  logic [REM_W-1:0]   rem_sh;
  logic [REM_W-1:0]   trial;
  logic [SUM_W-1:0]   quo_mean;
  logic [2*SUM_W-1:0] sq_full;
  msd_div_req_t       div_req;
  msd_div_rsp_t       div_rsp;

  msd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    pop      = (state == S_IDLE) && nonempty;
    head_mag = head.sum[SUM_W-1] ? (~head.sum + 1'b1) : head.sum;
    sq_full  = smag * smag;
    rem_sh   = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
    trial    = {root, 2'b01};
    quo_mean = div_rsp.quotient[SUM_W-1:0];
    div_req.start    = ((state == S_DIV_SD) && (n > COUNT_W'(1)))
                    || ((state == S_DIV_MEAN) && (n != '0));
    div_req.dividend = (state == S_DIV_SD) ? DIV_W'(root) : DIV_W'(smag);
    div_req.divisor  = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (nonempty) begin
            n      <= head.n;
            mplier <= head.n;
            neg    <= head.sum[SUM_W-1];
            ovf    <= head.ovf;
            smag   <= head_mag;
            mcand  <= P_W'(head.sumsq);
            acc    <= '0;
            step   <= '0;
            state  <= S_MUL;
          end
        end
        // Shift-and-add of N times the sum of squares, one count bit a cycle.
        S_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= {mcand[P_W-2:0], 1'b0};
          mplier <= {1'b0, mplier[COUNT_W-1:1]};
          sq_sum <= P_W'(sq_full);
          step   <= step + 1'b1;
          if (step == STEP_W'(COUNT_W - 1)) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          rad   <= (acc >= sq_sum) ? RAD_W'(acc - sq_sum) : '0;
          root  <= '0;
          rem   <= '0;
          step  <= '0;
          state <= S_ROOT;
        end
        // Digit-by-digit square root, two radicand bits a cycle.
        S_ROOT: begin
          if (rem_sh >= trial) begin
            rem  <= rem_sh - trial;
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            rem  <= rem_sh;
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          rad  <= {rad[RAD_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_W - 1)) begin
            state <= S_DIV_SD;
          end
        end
        S_DIV_SD: begin
          if (n > COUNT_W'(1)) begin
            state <= S_WAIT_SD;
          end else begin
            sd    <= '0;
            state <= S_DIV_MEAN;
          end
        end
        S_WAIT_SD: begin
          if (div_rsp.done) begin
            sd    <= div_rsp.quotient[RESULT_W-1:0];
            state <= S_DIV_MEAN;
          end
        end
        S_DIV_MEAN: begin
          if (n != '0) begin
            state <= S_WAIT_MEAN;
          end else begin
            mean      <= '0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_WAIT_MEAN: begin
          if (div_rsp.done) begin
            mean      <= neg ? RESULT_W'(~quo_mean + 1'b1) : RESULT_W'(quo_mean);
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          out_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid        = out_valid;
  assign results.mean         = mean;
  assign results.std_dev      = sd;
  assign results.sample_count = n;
  assign results.overflowed   = ovf;

endmodule

@@ hw/rtl/mean_and_std_deviation_unit.sv @@
// ----------------------------------------------------------------------------
// mean_and_std_deviation_unit
// Population mean and standard deviation of sets of signed Q8.8 samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle and summed as they arrive; the item marked
// last closes the set. Closed sets wait in a four-entry queue while a
// sequential finisher works on them, so the sample side keeps running at one
// item a cycle and only stalls while four closed sets wait for the finisher.
// Finishing one set takes a 13-step shift-add for N times the sum of squares,
// a 28-step square root and up to two divisions by the count in one shared
// divider. Up to 4096 samples are kept per set; further samples are dropped
// and flagged.
// ----------------------------------------------------------------------------
module mean_and_std_deviation_unit import msd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  msd_in_if.sink    samples,
  msd_out_if.source results
);

  logic              push;
  msd_set_t          push_set;
  logic              pop;
  msd_set_t          head;
  logic              nonempty;
  logic [QLVL_W-1:0] level;

  msd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .level    (level),
    .push     (push),
    .push_set (push_set)
  );

  msd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_set (push_set),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty),
    .level    (level)
  );

  msd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .results  (results)
  );

endmodule
